// ===== hdl/ppc_pkg.sv =====
// Package: shared types and constants for the polygon area/perimeter/centroid block.
package ppc_pkg;

  localparam int COORD_BITS = 16;
  localparam int SQRT_STEPS = 25;
  localparam int DIV_STEPS  = 62;
  localparam int CNT_W      = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LOAD,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MACC,
    ST_SQRT,
    ST_SQRT_END,
    ST_DIV_SETUP,
    ST_DIV,
    ST_DIV_END,
    ST_RESULT
  } ppc_state_t;

  typedef struct packed {
    logic take;
    logic set_first;
    logic load_edge;
    logic closing;
    logic mul1;
    logic mul2;
    logic mul3;
    logic macc;
    logic sqrt_step;
    logic sqrt_end;
    logic div_setup;
    logic div_sel;
    logic div_step;
    logic div_end;
    logic load_result;
  } ppc_cmd_t;

  typedef struct packed {
    logic degen;
  } ppc_status_t;

endpackage

// ===== hdl/ppc_if.sv =====
// Interfaces: vertex input channel and result output channel.
interface ppc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic               last_vertex;
  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface ppc_out_if;
  logic               valid;
  logic               ready;
  logic [32:0]        area_doubled;
  logic [36:0]        perimeter_length;
  logic signed [15:0] centroid_x;
  logic signed [15:0] centroid_y;
  logic               degenerate;
  modport source (output valid, area_doubled, perimeter_length, centroid_x, centroid_y,
                  degenerate, input ready);
  modport sink (input valid, area_doubled, perimeter_length, centroid_x, centroid_y,
                degenerate, output ready);
endinterface

// ===== hdl/polygon_area_perimeter_centroid_top.sv =====
// A vertex word keeps the block busy through LOAD, three product stages, MACC, 25 square-root
// steps and the length add before another word is taken; a first vertex is only stored in ST_FIRST.
// A last vertex adds the closing edge and two divisions before out valid rises; when the area
// is zero the divisions are skipped.
// One vertex word at a time; a finished result waits in the output register.
// Reset (rst_n low, synchronous) clears the controller, accumulators and output valid.
module polygon_area_perimeter_centroid_top import ppc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ppc_in_if.sink      in_if,
  ppc_out_if.source   out_if
);

  ppc_cmd_t    cmd;
  ppc_status_t status;

  ppc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_last   (in_if.last_vertex),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ppc_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_x    (in_if.vertex_x),
    .in_y    (in_if.vertex_y),
    .status  (status),
    .area_o  (out_if.area_doubled),
    .perim_o (out_if.perimeter_length),
    .cx_o    (out_if.centroid_x),
    .cy_o    (out_if.centroid_y),
    .degen_o (out_if.degenerate)
  );

endmodule

// ===== hdl/ppc_ctrl.sv =====
// Controller: sequences edge math, square root and the two closing divisions.
module ppc_ctrl import ppc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  ppc_status_t status,
  output ppc_cmd_t    cmd
);

  ppc_state_t       state_r, state_nxt;
  logic             have_first_r, have_first_nxt;
  logic             last_r, last_nxt;
  logic             closing_r, closing_nxt;
  logic             sel_r, sel_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      have_first_r <= 1'b0;
      last_r       <= 1'b0;
      closing_r    <= 1'b0;
      sel_r        <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      have_first_r <= have_first_nxt;
      last_r       <= last_nxt;
      closing_r    <= closing_nxt;
      sel_r        <= sel_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt      = state_r;
    have_first_nxt = have_first_r;
    last_nxt       = last_r;
    closing_nxt    = closing_r;
    sel_nxt        = sel_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          last_nxt    = in_last;
          closing_nxt = 1'b0;
          state_nxt   = have_first_r ? ST_LOAD : ST_FIRST;
        end
      end
      ST_FIRST: begin
        have_first_nxt = 1'b1;
        if (last_r) begin
          closing_nxt = 1'b1;
          state_nxt   = ST_LOAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOAD:  state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_MUL3;
      ST_MUL3:  state_nxt = ST_MACC;
      ST_MACC: begin
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = ST_SQRT_END;
      end
      ST_SQRT_END: begin
        if (closing_r) begin
          sel_nxt   = 1'b0;
          state_nxt = status.degen ? ST_RESULT : ST_DIV_SETUP;
        end else if (last_r) begin
          closing_nxt = 1'b1;
          state_nxt   = ST_LOAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV_SETUP: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_DIV_END;
      end
      ST_DIV_END: begin
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = ST_DIV_SETUP;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          have_first_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd         = '0;
    cmd.closing = closing_r;
    cmd.div_sel = sel_r;
    case (state_r)
      ST_IDLE:      cmd.take        = in_valid;
      ST_FIRST:     cmd.set_first   = 1'b1;
      ST_LOAD:      cmd.load_edge   = 1'b1;
      ST_MUL1:      cmd.mul1        = 1'b1;
      ST_MUL2:      cmd.mul2        = 1'b1;
      ST_MUL3:      cmd.mul3        = 1'b1;
      ST_MACC:      cmd.macc        = 1'b1;
      ST_SQRT:      cmd.sqrt_step   = 1'b1;
      ST_SQRT_END:  cmd.sqrt_end    = 1'b1;
      ST_DIV_SETUP: cmd.div_setup   = 1'b1;
      ST_DIV:       cmd.div_step    = 1'b1;
      ST_DIV_END:   cmd.div_end     = 1'b1;
      ST_RESULT:    cmd.load_result = out_free;
      default:      cmd.take        = 1'b0;
    endcase
  end

endmodule

// ===== hdl/ppc_datapath.sv =====
// Datapath: vertex registers, edge products, accumulators, sqrt and divide units.
module ppc_datapath import ppc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ppc_cmd_t           cmd,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  output ppc_status_t        status,
  output logic [32:0]        area_o,
  output logic [36:0]        perim_o,
  output logic signed [15:0] cx_o,
  output logic signed [15:0] cy_o,
  output logic               degen_o
);

  localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN = -COORD_MAX - 1;

  function automatic logic signed [15:0] clamp_coord(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (int'(v) > COORD_MAX) r = 16'(COORD_MAX);
    if (int'(v) < COORD_MIN) r = 16'(COORD_MIN);
    return r;
  endfunction

  logic signed [15:0] cur_x_r, cur_y_r, first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [15:0] xi_r, yi_r, xj_r, yj_r;
  logic signed [31:0] p1_r, p2_r;
  logic signed [16:0] dx_r, dy_r, sx_r, sy_r;
  logic signed [32:0] f_r;
  logic [31:0]        dx2_r, dy2_r;
  logic signed [49:0] mx_r, my_r;
  logic signed [39:0] cross_r;
  logic signed [61:0] momx_r, momy_r;
  logic [36:0]        len_r;
  logic [50:0]        rem_r, res_r, bit_r;
  logic [61:0]        q_r;
  logic [42:0]        drem_r;
  logic [41:0]        dsor_r;
  logic               neg_r;
  logic signed [15:0] cx_r, cy_r;

  logic signed [33:0] dxsq, dysq;
  logic signed [40:0] cross_s;
  logic signed [62:0] momx_s, momy_s;
  logic [37:0]        len_s;
  logic [50:0]        trial;
  logic [25:0]        root;
  logic signed [61:0] num;
  logic signed [41:0] dval;
  logic [42:0]        dshift, dtrial;
  logic signed [15:0] csat;
  logic [39:0]        area_mag;

  assign dxsq    = dx_r * dx_r;
  assign dysq    = dy_r * dy_r;
  assign cross_s = 41'(cross_r) + 41'(f_r);
  assign momx_s  = 63'(momx_r) + 63'(mx_r);
  assign momy_s  = 63'(momy_r) + 63'(my_r);
  assign trial   = res_r + bit_r;
  assign root    = (rem_r > res_r) ? 26'(res_r + 51'd1) : 26'(res_r);
  assign len_s   = 38'(len_r) + 38'(root);
  assign num     = cmd.div_sel ? momy_r : momx_r;
  assign dval    = 42'(cross_r) + (42'(cross_r) <<< 1);
  assign dshift  = {drem_r[41:0], q_r[61]};
  assign dtrial  = dshift - {1'b0, dsor_r};
  assign area_mag = cross_r[39] ? 40'(-cross_r) : 40'(cross_r);

  always_comb begin
    if (!neg_r) begin
      csat = (q_r > 62'd32767) ? 16'sh7fff : 16'(q_r[15:0]);
    end else begin
      csat = (q_r > 62'd32768) ? 16'sh8000 : 16'(-q_r[15:0]);
    end
  end

  assign status.degen = (cross_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_x_r <= clamp_coord(in_x);
      cur_y_r <= clamp_coord(in_y);
    end
    if (cmd.set_first) begin
      first_x_r <= cur_x_r;
      first_y_r <= cur_y_r;
      prev_x_r  <= cur_x_r;
      prev_y_r  <= cur_y_r;
    end
    if (cmd.load_edge) begin
      if (cmd.closing) begin
        xi_r <= cur_x_r;
        yi_r <= cur_y_r;
        xj_r <= first_x_r;
        yj_r <= first_y_r;
      end else begin
        xi_r     <= prev_x_r;
        yi_r     <= prev_y_r;
        xj_r     <= cur_x_r;
        yj_r     <= cur_y_r;
        prev_x_r <= cur_x_r;
        prev_y_r <= cur_y_r;
      end
    end
    if (cmd.mul1) begin
      p1_r <= xi_r * yj_r;
      p2_r <= xj_r * yi_r;
      dx_r <= 17'(xj_r) - 17'(xi_r);
      dy_r <= 17'(yj_r) - 17'(yi_r);
      sx_r <= 17'(xi_r) + 17'(xj_r);
      sy_r <= 17'(yi_r) + 17'(yj_r);
    end
    if (cmd.mul2) begin
      f_r   <= 33'(p1_r) - 33'(p2_r);
      dx2_r <= dxsq[31:0];
      dy2_r <= dysq[31:0];
    end
    if (cmd.mul3) begin
      mx_r  <= sx_r * f_r;
      my_r  <= sy_r * f_r;
      rem_r <= {2'b00, (33'(dx2_r) + 33'(dy2_r)), 16'h0000};
      res_r <= '0;
      bit_r <= 51'd1 << 48;
    end
    if (cmd.sqrt_step) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.div_setup) begin
      q_r    <= num[61] ? 62'(-num) : 62'(num);
      dsor_r <= dval[41] ? 42'(-dval) : 42'(dval);
      neg_r  <= num[61] ^ dval[41];
      drem_r <= '0;
    end
    if (cmd.div_step) begin
      if (!dtrial[42]) begin
        drem_r <= dtrial;
        q_r    <= {q_r[60:0], 1'b1};
      end else begin
        drem_r <= dshift;
        q_r    <= {q_r[60:0], 1'b0};
      end
    end
    if (cmd.div_end) begin
      if (cmd.div_sel) cy_r <= csat;
      else             cx_r <= csat;
    end
    if (cmd.load_result) begin
      area_o  <= (area_mag > 40'h1_ffff_ffff) ? '1 : area_mag[32:0];
      perim_o <= len_r;
      degen_o <= status.degen;
      cx_o    <= status.degen ? first_x_r : cx_r;
      cy_o    <= status.degen ? first_y_r : cy_r;
    end
  end

  // accumulators, saturating
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_result) begin
      cross_r <= '0;
      momx_r  <= '0;
      momy_r  <= '0;
      len_r   <= '0;
    end else begin
      if (cmd.mul3) begin
        if (cross_s[40] != cross_s[39])
          cross_r <= cross_s[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        else
          cross_r <= cross_s[39:0];
      end
      if (cmd.macc) begin
        if (momx_s[62] != momx_s[61])
          momx_r <= momx_s[62] ? {1'b1, 61'd0} : {1'b0, {61{1'b1}}};
        else
          momx_r <= momx_s[61:0];
        if (momy_s[62] != momy_s[61])
          momy_r <= momy_s[62] ? {1'b1, 61'd0} : {1'b0, {61{1'b1}}};
        else
          momy_r <= momy_s[61:0];
      end
      if (cmd.sqrt_end) len_r <= len_s[37] ? '1 : len_s[36:0];
    end
  end

endmodule
